// ===== hdl/lpt_pkg.sv =====
// Shared constants and request/response types for the trigger priority block.
package lpt_pkg;

   localparam int NUM_TRIGGERS = 4;
   localparam int LEVEL_W      = 4;
   localparam int ACT_W        = 2;
   localparam int IDX_W        = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;
   localparam int CNT_W        = $clog2(NUM_TRIGGERS + 1);

   typedef struct packed {
      logic [LEVEL_W-1:0] trigger_levels;
      logic               bank_button_level;
      logic               sweep_button_level;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] triggered_mask;
      logic [LEVEL_W-1:0] held_mask;
      logic [LEVEL_W-1:0] released_mask;
      logic [ACT_W-1:0]   active_index;
      logic               active_valid;
      logic               bank_toggle;
      logic               sweep_toggle;
   } rsp_type;

endpackage

// ===== hdl/lpt_channels.sv =====
// Valid/ready channel interfaces for requests and responses.
interface lpt_req_if;
   import lpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] trigger_levels;
   logic               bank_button_level;
   logic               sweep_button_level;

   modport source (output valid, output trigger_levels, output bank_button_level,
                   output sweep_button_level, input ready);
   modport sink (input valid, input trigger_levels, input bank_button_level,
                 input sweep_button_level, output ready);
endinterface

interface lpt_rsp_if;
   import lpt_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] triggered_mask;
   logic [LEVEL_W-1:0] held_mask;
   logic [LEVEL_W-1:0] released_mask;
   logic [ACT_W-1:0]   active_index;
   logic               active_valid;
   logic               bank_toggle;
   logic               sweep_toggle;

   modport source (output valid, output triggered_mask, output held_mask,
                   output released_mask, output active_index, output active_valid,
                   output bank_toggle, output sweep_toggle, input ready);
   modport sink (input valid, input triggered_mask, input held_mask,
                 input released_mask, input active_index, input active_valid,
                 input bank_toggle, input sweep_toggle, output ready);
endinterface

// ===== hdl/lpt_core.sv =====
// Edge detection, press-order stack and toggle state for one scan tick.
module lpt_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  lpt_pkg::req_type req_data,
   output lpt_pkg::rsp_type rsp_data
);
   import lpt_pkg::*;

   typedef struct packed {
      logic [NUM_TRIGGERS-1:0][IDX_W-1:0] entry;
      logic [CNT_W-1:0]                   count;
   } stack_type;

   function automatic stack_type stack_remove(stack_type s, logic [IDX_W-1:0] idx);
      stack_type        o;
      logic [CNT_W-1:0] w;
      o.entry = '0;
      w       = '0;
      for (int r = 0; r < NUM_TRIGGERS; r++) begin
         if (CNT_W'(r) < s.count && s.entry[r] != idx) begin
            o.entry[w[IDX_W-1:0]] = s.entry[r];
            w = w + CNT_W'(1);
         end
      end
      o.count = w;
      return o;
   endfunction

   function automatic stack_type stack_push_top(stack_type s, logic [IDX_W-1:0] idx);
      stack_type o;
      o = stack_remove(s, idx);
      if (o.count < CNT_W'(NUM_TRIGGERS)) begin
         o.entry[o.count[IDX_W-1:0]] = idx;
         o.count = o.count + CNT_W'(1);
      end
      return o;
   endfunction

   logic [NUM_TRIGGERS-1:0] prev_levels_ff, prev_levels_in;
   logic                    prev_bank_ff, prev_sweep_ff;
   stack_type               stack_ff, stack_in;
   logic [IDX_W-1:0]        held_index_ff, held_index_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    bank_ff, bank_in;
   logic                    sweep_ff, sweep_in;
   logic [NUM_TRIGGERS-1:0] rise, fall;
   logic [CNT_W-1:0]        top_pos;

   always_comb begin
      prev_levels_in = '0;
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
         if (i < LEVEL_W) begin
            prev_levels_in[i] = req_data.trigger_levels[i];
         end
      end
      rise = prev_levels_in & ~prev_levels_ff;
      fall = ~prev_levels_in & prev_levels_ff;

      stack_in = stack_ff;
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
         if (rise[i]) begin
            stack_in = stack_push_top(stack_in, IDX_W'(i));
         end else if (fall[i]) begin
            stack_in = stack_remove(stack_in, IDX_W'(i));
         end
      end

      top_pos       = stack_in.count - CNT_W'(1);
      held_index_in = held_index_ff;
      held_valid_in = held_valid_ff;
      if (stack_in.count != '0) begin
         held_index_in = stack_in.entry[top_pos[IDX_W-1:0]];
         held_valid_in = 1'b1;
      end

      bank_in  = bank_ff ^ (req_data.bank_button_level & ~prev_bank_ff);
      sweep_in = sweep_ff ^ (req_data.sweep_button_level & ~prev_sweep_ff);

      rsp_data = '0;
      for (int i = 0; i < LEVEL_W; i++) begin
         if (i < NUM_TRIGGERS) begin
            rsp_data.triggered_mask[i] = rise[i];
            rsp_data.held_mask[i]      = prev_levels_in[i];
            rsp_data.released_mask[i]  = fall[i];
         end
      end
      rsp_data.active_index = ACT_W'(held_index_in);
      rsp_data.active_valid = held_valid_in;
      rsp_data.bank_toggle  = bank_in;
      rsp_data.sweep_toggle = sweep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         prev_bank_ff   <= 1'b0;
         prev_sweep_ff  <= 1'b0;
         stack_ff       <= '0;
         held_index_ff  <= '0;
         held_valid_ff  <= 1'b0;
         bank_ff        <= 1'b0;
         sweep_ff       <= 1'b0;
      end else if (advance) begin
         prev_levels_ff <= prev_levels_in;
         prev_bank_ff   <= req_data.bank_button_level;
         prev_sweep_ff  <= req_data.sweep_button_level;
         stack_ff       <= stack_in;
         held_index_ff  <= held_index_in;
         held_valid_ff  <= held_valid_in;
         bank_ff        <= bank_in;
         sweep_ff       <= sweep_in;
      end
   end

endmodule

// ===== hdl/last_pressed_trigger_priority.sv =====
// Top level: request register, scan-tick core and response register.
// Path: request register, then the core, then the response register.
// Throughput: one request per cycle; the request and response registers
// stall together only while a response waits and rsp ready is low.
// Reset: synchronous, active high; clears both stages, edge history, the
// press stack and the toggles. No clearing pass.
module last_pressed_trigger_priority (
   input logic clock,
   input logic reset,
   lpt_req_if.sink   req_chan,
   lpt_rsp_if.source rsp_chan
);
   import lpt_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_next;
   logic    advance;
   logic    take;

   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   lpt_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_data (req_data_ff),
      .rsp_data (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payloads while stalled
   always_ff @(posedge clock) begin
      if (take) begin
         req_data_ff.trigger_levels     <= req_chan.trigger_levels;
         req_data_ff.bank_button_level  <= req_chan.bank_button_level;
         req_data_ff.sweep_button_level <= req_chan.sweep_button_level;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.triggered_mask = rsp_data_ff.triggered_mask;
   assign rsp_chan.held_mask      = rsp_data_ff.held_mask;
   assign rsp_chan.released_mask  = rsp_data_ff.released_mask;
   assign rsp_chan.active_index   = rsp_data_ff.active_index;
   assign rsp_chan.active_valid   = rsp_data_ff.active_valid;
   assign rsp_chan.bank_toggle    = rsp_data_ff.bank_toggle;
   assign rsp_chan.sweep_toggle   = rsp_data_ff.sweep_toggle;

endmodule
